>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; expects a clock named clock and a reset named reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed");

`endif

>>> rtl/nwra_pkg.sv
// types, constants and state codes of the normalized weighted ring average
// no dependencies
`default_nettype none

package nwra_pkg;

   localparam int RING_DEPTH_DEFAULT = 64;
   localparam int SLOT_W   = 6;
   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int TAPS_W   = 7;
   localparam int QUOT_W   = 17;

   localparam logic [COEFF_W-1:0] THRESHOLD_RESET = 16'd33;

   typedef enum logic [0:0] {
      CMD_LOAD_WEIGHT = 1'b0,
      CMD_FILTER      = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MAC,
      ST_DIV
   } state_type;

   typedef struct packed {
      command_type                 command;
      logic [SLOT_W-1:0]           sample_slot;
      logic signed [SAMPLE_W-1:0]  sample;
      logic [SLOT_W-1:0]           coeff_slot;
      logic [COEFF_W-1:0]          coeff_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  filtered;
      logic                        zero_weight;
      logic [TAPS_W-1:0]           taps_used;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/nwra_ram.sv
// single write port, single read port memory with registered read data
// depends on nothing but its parameters
`default_nettype none

module nwra_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/nwra_div.sv
// iterative signed by unsigned divider, one quotient bit per cycle, truncates toward zero
// depends on nwra_pkg; quotient magnitude must stay below 2**QUOT_W
`default_nettype none

module nwra_div
   import nwra_pkg::*;
#(
   parameter int ACC_W  = 40,
   parameter int WSUM_W = 23
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [ACC_W-1:0]    dividend,
   input  wire logic        [WSUM_W-1:0]   divisor,
   output logic                            busy,
   output logic signed [SAMPLE_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              neg_ff, neg_in;
   logic [ACC_W-1:0]  magnitude;
   logic [QUOT_W-1:0] quot_signed;

   always_comb begin
      magnitude = dividend[ACC_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      neg_in  = neg_ff;
      if (start) begin
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = magnitude;
         den_in  = ACC_W'(divisor) << (QUOT_W - 1);
         quot_in = '0;
         neg_in  = dividend[ACC_W-1];
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         den_in = den_ff >> 1;
         if (rem_ff >= den_ff) begin
            rem_in  = rem_ff - den_ff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
   end

   assign quot_signed = neg_ff ? (~quot_ff + 1'b1) : quot_ff;
   assign quotient    = $signed(quot_signed[SAMPLE_W-1:0]);
   assign busy        = (cnt_ff != '0);

endmodule

`default_nettype wire

>>> rtl/normalized_weighted_ring_average.sv
// channel   dir  handshake            payload
// req_      in   req_valid/req_ready  req_type: command, slots, sample, weight
// rsp_      out  rsp_valid/rsp_ready  rsp_type: filtered, zero_weight, taps_used
// csr_      in   csr_valid/csr_ready  csr_data: weight_threshold
//
// a weight load is written at accept; a filter command runs as: accept, a fetch state,
// one tap per cycle through the memory read ports until the walk ends (a weight below
// the threshold also ends it), a divider start, 17 divider steps and a result load.
// after reset a clearing pass zeroes both memories while req_ready stays low. a result
// waiting on rsp_ready does not block the next transfer in, only the next result load.
//
// top level: control sequencer, tap accumulator, memories and divider
// depends on nwra_pkg, nwra_ram, nwra_div and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module normalized_weighted_ring_average
   import nwra_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_payload,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [COEFF_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int ACC_W  = 2 * SAMPLE_W + 1 + CNT_W;
   localparam int WSUM_W = COEFF_W + CNT_W;

   state_type                  state_ff, state_in;
   logic [ADDR_W-1:0]          clr_ff, clr_in;
   logic [CNT_W-1:0]           taps_ff, taps_in;
   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic [ADDR_W-1:0]          start_ff, start_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [WSUM_W-1:0]          wsum_ff, wsum_in;
   logic [COEFF_W-1:0]         thr_ff, thr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       div_go_ff, div_go_in;

   logic [ADDR_W-1:0]          slot_mod [2**SLOT_W];
   logic                       accept;
   logic                       smp_we, wt_we;
   logic [ADDR_W-1:0]          smp_waddr, wt_waddr;
   logic [SAMPLE_W-1:0]        smp_wdata;
   logic [COEFF_W-1:0]         wt_wdata;
   logic [SAMPLE_W-1:0]        smp_rdata;
   logic [COEFF_W-1:0]         wt_rdata;
   logic signed [2*SAMPLE_W:0] prod;
   logic                       tap_used;
   logic [ADDR_W-1:0]          pos_dec;
   logic [CNT_W-1:0]           taps_inc;
   logic                       div_busy;
   logic signed [SAMPLE_W-1:0] div_quot;

   for (genvar i = 0; i < 2**SLOT_W; i++) begin : g_slot_mod
      assign slot_mod[i] = ADDR_W'(i % RING_DEPTH);
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      smp_we    = 1'b0;
      wt_we     = 1'b0;
      smp_waddr = slot_mod[req_payload.sample_slot];
      wt_waddr  = slot_mod[req_payload.coeff_slot];
      smp_wdata = req_payload.sample;
      wt_wdata  = req_payload.coeff_value;
      if (state_ff == ST_CLEAR) begin
         smp_we    = 1'b1;
         wt_we     = 1'b1;
         smp_waddr = clr_ff;
         wt_waddr  = clr_ff;
         smp_wdata = '0;
         wt_wdata  = '0;
      end else if (accept) begin
         smp_we = (req_payload.command == CMD_FILTER);
         wt_we  = (req_payload.command == CMD_LOAD_WEIGHT);
      end
   end

   nwra_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (SAMPLE_W)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_we),
      .wr_addr (smp_waddr),
      .wr_data (smp_wdata),
      .rd_addr (pos_in),
      .rd_data (smp_rdata)
   );

   nwra_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (COEFF_W)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (wt_wdata),
      .rd_addr (taps_in[ADDR_W-1:0]),
      .rd_data (wt_rdata)
   );

   nwra_div #(
      .ACC_W  (ACC_W),
      .WSUM_W (WSUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (acc_ff),
      .divisor  (wsum_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign prod     = $signed({1'b0, wt_rdata}) * $signed(smp_rdata);
   assign tap_used = (taps_ff == '0) || (wt_rdata >= thr_ff);
   assign pos_dec  = (pos_ff == '0) ? ADDR_W'(RING_DEPTH - 1) : pos_ff - 1'b1;
   assign taps_inc = taps_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      taps_in      = taps_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      acc_in       = acc_ff;
      wsum_in      = wsum_ff;
      thr_in       = csr_valid ? csr_data : thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_go_in    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(RING_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_payload.command == CMD_FILTER) begin
               start_in = slot_mod[req_payload.sample_slot];
               pos_in   = slot_mod[req_payload.sample_slot];
               taps_in  = '0;
               acc_in   = '0;
               wsum_in  = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (tap_used) begin
               acc_in  = acc_ff + ACC_W'(prod);
               wsum_in = wsum_ff + WSUM_W'(wt_rdata);
               taps_in = taps_inc;
               pos_in  = pos_dec;
               if (pos_dec == start_ff || taps_inc >= CNT_W'(RING_DEPTH)) begin
                  div_go_in = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_go_ff && !div_busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.zero_weight = (wsum_ff == '0);
               rsp_in.filtered    = (wsum_ff == '0) ? '0 : div_quot;
               rsp_in.taps_used   = TAPS_W'(taps_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         taps_ff      <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         taps_ff      <= taps_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         div_go_ff    <= div_go_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      start_ff <= start_in;
      acc_ff   <= acc_in;
      wsum_ff  <= wsum_in;
      rsp_ff   <= rsp_in;
   end

   `ASSERT_CLK(a_taps_bounded, taps_ff <= CNT_W'(RING_DEPTH))
   `ASSERT_CLK(a_div_free_at_start, div_go_ff |-> !div_busy)
   `ASSERT_CLK(a_zero_flag_clears_value,
      rsp_valid |-> (!rsp_payload.zero_weight || rsp_payload.filtered == '0))
   `ASSERT_CLK(a_result_only_after_div,
      $rose(rsp_valid) |-> $past(state_ff) == ST_DIV)

endmodule

`default_nettype wire
